@@ sv/flow_meter_totalizer_assert.svh @@
// Assertion macros shared by the flow meter totalizer RTL.
// Expects clk and rst_n in the scope of use.
`ifndef FLOW_METER_TOTALIZER_ASSERT_SVH
`define FLOW_METER_TOTALIZER_ASSERT_SVH

// Same-cycle implication.
`define FMT_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("flow meter totalizer: same-cycle check failed");

// Next-cycle implication.
`define FMT_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("flow meter totalizer: next-cycle check failed");

`endif

@@ sv/fmt_pkg.sv @@
// Shared widths, codes and controller/datapath types for the flow meter totalizer.
// No dependencies.
`timescale 1ns / 1ps

package fmt_pkg;

  localparam int DW          = 32;
  localparam int CAL_W       = 16;
  localparam int OP_W        = 2;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 16;

  localparam int NUM_W       = 64;
  localparam int DEN_W       = 48;
  localparam int Q_W         = 32;
  localparam int CNT_W       = $clog2(Q_W + 1);

  localparam int ML_PROD_W   = 42;
  localparam int RATE_PROD_W = 52;
  localparam int RATE_FRAC   = 8;

  localparam logic [CAL_W-1:0] CAL_RESET    = 16'd450;
  localparam logic             FILL_RESET   = 1'b1;
  localparam logic [9:0]       ML_PER_LITRE = 10'd1000;
  localparam logic [19:0]      UL_PER_LITRE = 20'd1000000;

  localparam logic [DW-1:0] TOT_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] TOT_MIN = {1'b1, {(DW-1){1'b0}}};

  typedef enum logic [OP_W-1:0] {
    OP_PULSE      = 2'd0,
    OP_TICK       = 2'd1,
    OP_CLR_PULSES = 2'd2,
    OP_CLR_TOTAL  = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAL  = 1'b0,
    CFG_FILL = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic take;
    logic mul;
    logic div_start;
    logic finish;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } sts_t;

endpackage

@@ sv/fmt_ifs.sv @@
// Channel interfaces of the flow meter totalizer: input, result and config write.
// Depends on fmt_pkg.
`timescale 1ns / 1ps

interface fmt_in_if import fmt_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [OP_W-1:0] operation;
  logic [DW-1:0]   now_ms;

  modport source (output valid, operation, now_ms, input ready);
  modport sink   (input valid, operation, now_ms, output ready);
endinterface

interface fmt_out_if import fmt_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [DW-1:0]        pulse_count;
  logic signed [DW-1:0] total_ml;
  logic [DW-1:0]        flow_rate_q8;
  logic                 rate_valid;

  modport source (output valid, pulse_count, total_ml, flow_rate_q8, rate_valid, input ready);
  modport sink   (input valid, pulse_count, total_ml, flow_rate_q8, rate_valid, output ready);
endinterface

interface fmt_cfg_if import fmt_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ sv/fmt_div.sv @@
// Restoring divider, one quotient bit per cycle, 32-bit saturated quotient.
// Depends on fmt_pkg.
`timescale 1ns / 1ps

module fmt_div import fmt_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic             ovf,
  output logic [Q_W-1:0]   quot
);

  logic             busy_r, busy_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             ovf_r;
  logic [DEN_W-1:0] rem_r, den_r;
  logic [Q_W-1:0]   lo_r;

  logic [DEN_W:0]   trial, diff;
  logic             fits;

  assign trial = {rem_r, lo_r[Q_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign fits  = !diff[DEN_W];

  assign done = busy_r && (cnt_r == '0);
  assign ovf  = ovf_r;
  assign quot = ovf_r ? '1 : lo_r;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(Q_W);
    end else if (busy_r) begin
      if (cnt_r == '0) busy_nxt = 1'b0;
      else cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ovf_r <= DEN_W'(num[NUM_W-1:Q_W]) >= den;
      rem_r <= DEN_W'(num[NUM_W-1:Q_W]);
      lo_r  <= num[Q_W-1:0];
      den_r <= den;
    end else if (busy_r && (cnt_r != '0)) begin
      rem_r <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      lo_r  <= {lo_r[Q_W-2:0], fits};
    end
  end

endmodule

@@ sv/fmt_ctrl.sv @@
// Controller of the flow meter totalizer: sequences beats, tick math and result hand-off.
// Depends on fmt_pkg.
`timescale 1ns / 1ps

module fmt_ctrl import fmt_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  op_t  in_op,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_LOAD,
    S_DIV,
    S_RESP
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = (in_op == OP_TICK) ? S_MUL : S_RESP;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.finish = 1'b1;
          state_nxt  = S_RESP;
        end
      end
      S_RESP: begin
        if (slot_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ sv/fmt_dpath.sv @@
// Datapath of the flow meter totalizer: config, counters, total, rate, result register.
// Depends on fmt_pkg and fmt_div.
`timescale 1ns / 1ps

module fmt_dpath import fmt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  op_t                   in_op,
  input  logic [DW-1:0]         in_now,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  output logic [DW-1:0]         out_pulse_count,
  output logic [DW-1:0]         out_total_ml,
  output logic [DW-1:0]         out_flow_rate_q8,
  output logic                  out_rate_valid
);

  logic [CAL_W-1:0] cal_r;
  logic             fill_r;

  logic [DW-1:0] pcnt_r, pcnt_nxt;
  logic [DW-1:0] total_r, total_nxt;
  logic [DW-1:0] last_r, last_nxt;
  logic [DW-1:0] rate_r, rate_nxt;
  logic          rok_r, rok_nxt;

  logic [DW-1:0]          now_r;
  logic [ML_PROD_W-1:0]   prod_ml_r;
  logic [RATE_PROD_W-1:0] prod_rate_r;
  logic [DEN_W-1:0]       den_rate_r;
  logic                   ezero_r;

  logic [DW-1:0] pc_q_r, tot_q_r, rate_q_r;
  logic          rv_q_r;

  logic [CAL_W-1:0] cal_eff;
  logic [DW-1:0]    elapsed;
  logic             ml_done, rate_done, ml_ovf, rate_ovf;
  logic [Q_W-1:0]   q_ml, q_rate;
  logic [DW+1:0]    tot_ext, ml_ext, sum;
  logic [DW-1:0]    total_upd;

  assign cal_eff = (cal_r == '0) ? CAL_W'(1) : cal_r;
  assign elapsed = now_r - last_r;

  fmt_div u_div_ml (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (NUM_W'(prod_ml_r)),
    .den   (DEN_W'(cal_eff)),
    .done  (ml_done),
    .ovf   (ml_ovf),
    .quot  (q_ml)
  );

  fmt_div u_div_rate (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (NUM_W'({prod_rate_r, {RATE_FRAC{1'b0}}})),
    .den   (den_rate_r),
    .done  (rate_done),
    .ovf   (rate_ovf),
    .quot  (q_rate)
  );

  assign sts.div_done = ml_done && rate_done;

  // adds or drains the tick volume; volume beyond 32 bits, or a sum outside the signed range, saturates the total
  always_comb begin
    tot_ext = {{2{total_r[DW-1]}}, total_r};
    ml_ext  = {2'b00, q_ml};
    sum     = fill_r ? (tot_ext + ml_ext) : (tot_ext - ml_ext);
    if (ml_ovf) total_upd = fill_r ? TOT_MAX : TOT_MIN;
    else if ((sum[DW+1] != sum[DW-1]) || (sum[DW] != sum[DW-1]))
      total_upd = sum[DW+1] ? TOT_MIN : TOT_MAX;
    else total_upd = sum[DW-1:0];
  end

  always_comb begin
    pcnt_nxt  = pcnt_r;
    total_nxt = total_r;
    last_nxt  = last_r;
    rate_nxt  = rate_r;
    rok_nxt   = rok_r;
    if (cmd.take) begin
      case (in_op)
        OP_PULSE:      if (pcnt_r != '1) pcnt_nxt = pcnt_r + 1'b1;
        OP_TICK:       ;
        OP_CLR_PULSES: pcnt_nxt = '0;
        OP_CLR_TOTAL:  total_nxt = '0;
        default:       ;
      endcase
    end
    if (cmd.finish) begin
      total_nxt = total_upd;
      rate_nxt  = (ezero_r || rate_ovf) ? '1 : q_rate;
      rok_nxt   = !ezero_r;
      pcnt_nxt  = '0;
      last_nxt  = now_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r   <= CAL_RESET;
      fill_r  <= FILL_RESET;
      pcnt_r  <= '0;
      total_r <= '0;
      last_r  <= '0;
      rate_r  <= '0;
      rok_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_idx))
          CFG_CAL:  cal_r  <= cfg_data[CAL_W-1:0];
          CFG_FILL: fill_r <= cfg_data[0];
          default:  ;
        endcase
      end
      pcnt_r  <= pcnt_nxt;
      total_r <= total_nxt;
      last_r  <= last_nxt;
      rate_r  <= rate_nxt;
      rok_r   <= rok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) now_r <= in_now;
    if (cmd.mul) begin
      prod_ml_r   <= ML_PROD_W'(pcnt_r) * ML_PROD_W'(ML_PER_LITRE);
      prod_rate_r <= RATE_PROD_W'(pcnt_r) * RATE_PROD_W'(UL_PER_LITRE);
      den_rate_r  <= DEN_W'(cal_eff) * DEN_W'(elapsed);
      ezero_r     <= (elapsed == '0);
    end
    if (cmd.load_out) begin
      pc_q_r   <= pcnt_r;
      tot_q_r  <= total_r;
      rate_q_r <= rate_r;
      rv_q_r   <= rok_r;
    end
  end

  assign out_pulse_count  = pc_q_r;
  assign out_total_ml     = tot_q_r;
  assign out_flow_rate_q8 = rate_q_r;
  assign out_rate_valid   = rv_q_r;

endmodule

@@ sv/flow_meter_totalizer.sv @@
// Pulse flow meter totalizer: pulse counter, signed volume total and Q24.8 flow rate.
// Top level; depends on fmt_pkg, fmt_ifs, fmt_ctrl, fmt_dpath, fmt_div and the assert header.
//
// One input beat is handled at a time and every beat returns one result beat. Pulse and
// clear beats go from acceptance straight to the result state; a tick passes through the
// product, load and divide states (the 32-step restoring dividers for volume and rate run
// side by side) before it. The result register lets the next beat in as soon as it is
// loaded, even while the sink stalls; a further result waits until that register drains.
// Config writes are always accepted and apply on the write beat.
`timescale 1ns / 1ps

`include "flow_meter_totalizer_assert.svh"

module flow_meter_totalizer import fmt_pkg::*; (
  input logic         clk,
  input logic         rst_n,
  fmt_in_if.sink      in_ch,
  fmt_out_if.source   out_ch,
  fmt_cfg_if.sink     cfg_ch
);

  cmd_t          cmd;
  sts_t          sts;
  op_t           in_op;
  logic [DW-1:0] total_bits;

  assign in_op        = op_t'(in_ch.operation);
  assign cfg_ch.ready = 1'b1;

  fmt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_op     (in_op),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fmt_dpath u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_op            (in_op),
    .in_now           (in_ch.now_ms),
    .cfg_we           (cfg_ch.valid && cfg_ch.ready),
    .cfg_idx          (cfg_ch.index),
    .cfg_data         (cfg_ch.data),
    .cmd              (cmd),
    .sts              (sts),
    .out_pulse_count  (out_ch.pulse_count),
    .out_total_ml     (total_bits),
    .out_flow_rate_q8 (out_ch.flow_rate_q8),
    .out_rate_valid   (out_ch.rate_valid)
  );

  assign out_ch.total_ml = $signed(total_bits);

  `FMT_ASSERT_NEXT(a_tick_to_mul, cmd.take && (in_op == OP_TICK), cmd.mul)
  `FMT_ASSERT_NEXT(a_load_gives_valid, cmd.load_out, out_ch.valid)
  `FMT_ASSERT_IMPL(a_done_not_idle, sts.div_done, !in_ch.ready)
  `FMT_ASSERT_IMPL(a_done_finishes, sts.div_done, cmd.finish)

endmodule

@@ tb/sv/flow_meter_totalizer_tb.sv @@
// Self-checking testbench for flow_meter_totalizer: directed and random beats, randomized
// stalls on both channels, scoreboard against a built-in totalizer predictor.
// Depends on fmt_pkg, fmt_ifs and the flow_meter_totalizer RTL.
`timescale 1ns / 1ps

module flow_meter_totalizer_tb;
  import fmt_pkg::*;

  localparam longint          TOTAL_HI    = 64'sh7FFF_FFFF;
  localparam longint          TOTAL_LO    = -64'sh8000_0000;
  localparam longint unsigned ML_SCALE    = 64'd1000;
  localparam longint unsigned RATE_SCALE  = 64'd256_000_000;
  localparam int              PHASES      = 8;
  localparam int              PHASE_ITEMS = 240;

  typedef struct packed {
    op_t           op;
    logic [DW-1:0] now;
  } meter_cmd_t;

  typedef struct packed {
    logic [DW-1:0] pulses;
    logic [DW-1:0] total;
    logic [DW-1:0] rate;
    logic          ok;
  } meter_reading_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  fmt_in_if  in_bus();
  fmt_out_if out_bus();
  fmt_cfg_if cfg_bus();

  flow_meter_totalizer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  always #2 clk = ~clk;

  // predicted meter state
  logic [CAL_W-1:0]     cal_reg;
  logic                 fill_reg;
  logic [DW-1:0]        pulse_cnt;
  logic signed [DW-1:0] total_ml;
  logic [DW-1:0]        last_tick_ms;
  logic [DW-1:0]        rate_q8;
  logic                 rate_ok;

  meter_cmd_t     pending_cmds[$];
  meter_reading_t readings_due[$];
  int             n_queued;
  int             n_accepted;
  int             mismatches;
  logic           idle_on;
  logic           in_acc;
  int             in_gap;
  int             out_stall;
  logic [DW-1:0]  gen_ms;

  function automatic meter_reading_t totalize(op_t op, logic [DW-1:0] now);
    longint unsigned cal;
    longint unsigned ml;
    longint unsigned quot;
    longint          acc;
    logic [DW-1:0]   elapsed;
    meter_reading_t  r;
    case (op)
      OP_PULSE: begin
        if (pulse_cnt != '1) pulse_cnt = pulse_cnt + 1'b1;
      end
      OP_TICK: begin
        cal     = (cal_reg == '0) ? 64'd1 : 64'(cal_reg);
        ml      = 64'(pulse_cnt) * ML_SCALE / cal;
        elapsed = now - last_tick_ms;
        acc     = longint'(total_ml);
        acc     = fill_reg ? acc + longint'(ml) : acc - longint'(ml);
        if (acc > TOTAL_HI) acc = TOTAL_HI;
        else if (acc < TOTAL_LO) acc = TOTAL_LO;
        total_ml = 32'(acc);
        if (elapsed == '0) begin
          rate_q8 = '1;
          rate_ok = 1'b0;
        end else begin
          quot    = 64'(pulse_cnt) * RATE_SCALE / (cal * 64'(elapsed));
          rate_q8 = (quot > 64'hFFFF_FFFF) ? '1 : 32'(quot);
          rate_ok = 1'b1;
        end
        pulse_cnt    = '0;
        last_tick_ms = now;
      end
      OP_CLR_PULSES: pulse_cnt = '0;
      default:       total_ml  = '0;
    endcase
    r.pulses = pulse_cnt;
    r.total  = total_ml;
    r.rate   = rate_q8;
    r.ok     = rate_ok;
    return r;
  endfunction

  task automatic queue_cmd(op_t op, logic [DW-1:0] now);
    meter_cmd_t c;
    c.op  = op;
    c.now = now;
    pending_cmds.push_back(c);
    n_queued++;
    if (op == OP_TICK) gen_ms = now;
  endtask

  // wait for every queued beat to be accepted and answered
  task automatic settle();
    while (n_accepted != n_queued || readings_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    case (idx)
      CFG_CAL:  cal_reg  = val;
      default:  fill_reg = val[0];
    endcase
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  // mostly pulse bursts closed by a tick, with clears and random beats mixed in
  task automatic random_phase(int n);
    int            made;
    int            k;
    int            pick;
    logic [DW-1:0] dt;
    made = 0;
    while (made < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 78) begin
        k = ($urandom_range(0, 19) == 0) ? $urandom_range(41, 150) : $urandom_range(0, 40);
        repeat (k) queue_cmd(OP_PULSE, $urandom);
        case ($urandom_range(0, 9))
          0:       dt = '0;
          1, 2:    dt = $urandom_range(1, 3);
          3:       dt = $urandom;
          default: dt = $urandom_range(1, 5000);
        endcase
        queue_cmd(OP_TICK, gen_ms + dt);
        made += k + 1;
      end else begin
        if (pick < 86) queue_cmd(OP_CLR_PULSES, $urandom);
        else if (pick < 91) queue_cmd(OP_CLR_TOTAL, $urandom);
        else queue_cmd(op_t'($urandom_range(0, 3)), $urandom);
        made++;
      end
    end
  endtask

  // input driver
  always @(negedge clk) begin
    meter_cmd_t c;
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else if (in_bus.valid && !in_acc) begin
      // beat still waiting for ready
    end else if (in_gap > 0) begin
      in_bus.valid <= 1'b0;
      in_gap = in_gap - 1;
    end else if (pending_cmds.size() != 0 && idle_on && $urandom_range(0, 7) == 0) begin
      in_bus.valid <= 1'b0;
      in_gap = $urandom_range(0, 13);
    end else if (pending_cmds.size() != 0) begin
      c = pending_cmds.pop_front();
      in_bus.valid     <= 1'b1;
      in_bus.operation <= c.op;
      in_bus.now_ms    <= c.now;
    end else begin
      in_bus.valid <= 1'b0;
    end
  end

  // result sink backpressure
  always @(negedge clk) begin
    if (out_stall > 0) begin
      out_bus.ready <= 1'b0;
      out_stall = out_stall - 1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      out_bus.ready <= 1'b0;
      out_stall = $urandom_range(0, 13);
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  // monitor and scoreboard
  always @(posedge clk) begin
    meter_reading_t want;
    meter_reading_t got;
    in_acc <= rst_n && in_bus.valid && in_bus.ready;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      got.pulses = out_bus.pulse_count;
      got.total  = out_bus.total_ml;
      got.rate   = out_bus.flow_rate_q8;
      got.ok     = out_bus.rate_valid;
      if (readings_due.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: unexpected reading: pulses %0d total %0d rate %h valid %b", $time,
                   got.pulses, $signed(got.total), got.rate, got.ok);
        mismatches++;
      end else begin
        want = readings_due.pop_front();
        if (got.pulses !== want.pulses || got.total !== want.total ||
            got.rate !== want.rate || got.ok !== want.ok) begin
          if (mismatches < 10)
            $display("%0t: pulses/total/rate/valid exp %0d %0d %h %b, got %0d %0d %h %b",
                     $time, want.pulses, $signed(want.total), want.rate, want.ok,
                     got.pulses, $signed(got.total), got.rate, got.ok);
          mismatches++;
        end
      end
    end
    if (rst_n && in_bus.valid && in_bus.ready) begin
      readings_due.push_back(totalize(op_t'(in_bus.operation), in_bus.now_ms));
      n_accepted++;
    end
  end

  initial begin
    #4_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    logic [CFG_DATA_W-1:0] cal_val;
    logic [CFG_DATA_W-1:0] fill_val;
    in_bus.valid     = 1'b0;
    in_bus.operation = OP_PULSE;
    in_bus.now_ms    = '0;
    out_bus.ready    = 1'b0;
    cfg_bus.valid    = 1'b0;
    cfg_bus.index    = CFG_CAL;
    cfg_bus.data     = '0;
    in_acc       = 1'b0;
    in_gap       = 0;
    out_stall    = 0;
    n_queued     = 0;
    n_accepted   = 0;
    mismatches   = 0;
    idle_on      = 1'b1;
    gen_ms       = '0;
    cal_reg      = CAL_RESET;
    fill_reg     = FILL_RESET;
    pulse_cnt    = '0;
    total_ml     = '0;
    last_tick_ms = '0;
    rate_q8      = '0;
    rate_ok      = 1'b0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // reset calibration; first tick at time zero has no elapsed time
    queue_cmd(OP_TICK, '0);
    queue_cmd(OP_PULSE, '1);
    queue_cmd(OP_PULSE, '0);
    queue_cmd(OP_PULSE, 32'hA5A5_5A5A);
    queue_cmd(OP_TICK, 32'd1000);
    queue_cmd(OP_PULSE, 32'h5A5A_A5A5);
    queue_cmd(OP_CLR_PULSES, '1);
    queue_cmd(OP_PULSE, '0);
    queue_cmd(OP_TICK, '1);
    queue_cmd(OP_PULSE, '0);
    queue_cmd(OP_PULSE, '0);
    queue_cmd(OP_TICK, '0);       // time wraps
    queue_cmd(OP_CLR_TOTAL, '1);
    queue_cmd(OP_TICK, '0);       // same time again
    settle();

    // one pulse per litre, draining
    write_reg(CFG_CAL, 16'd1);
    write_reg(CFG_FILL, 16'hFFFE);
    queue_cmd(OP_PULSE, '0);
    queue_cmd(OP_PULSE, '0);
    queue_cmd(OP_PULSE, '0);
    queue_cmd(OP_TICK, 32'd3);
    queue_cmd(OP_TICK, 32'd3);
    settle();

    // zero calibration acts as one
    write_reg(CFG_CAL, 16'd0);
    write_reg(CFG_FILL, 16'd1);
    queue_cmd(OP_PULSE, '0);
    queue_cmd(OP_PULSE, '0);
    queue_cmd(OP_TICK, 32'd5);

    for (int p = 0; p < PHASES; p++) begin
      settle();
      case (p)
        0:       cal_val = 16'hFFFF;
        1:       cal_val = 16'd1;
        2:       cal_val = 16'd0;
        3:       cal_val = CAL_RESET;
        default: cal_val = $urandom_range(0, 65535);
      endcase
      fill_val    = $urandom_range(0, 65535);
      fill_val[0] = (p % 3 != 1);
      write_reg(CFG_CAL, cal_val);
      write_reg(CFG_FILL, fill_val);
      idle_on = (p != PHASES - 1);
      random_phase(PHASE_ITEMS);
    end

    settle();
    repeat (40) @(negedge clk);
    if (mismatches == 0 && readings_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
